// ----- rtl/esd_pkg.sv -----
// ----------------------------------------------------------------------------
// esd_pkg: shared types and constants of the escape sequence key decoder
// Holds the byte classes, key codes, parser phases and the token that the
// front end passes through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  // Queue between front end and back end.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Number accumulator.
  localparam int unsigned NumW  = 10;
  localparam int unsigned ProdW = NumW + 4;
  localparam logic [NumW-1:0] NumMax = '1;

  // Bytes of interest.
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChSs3   = 8'h4F;
  localparam logic [7:0] ChCsi   = 8'h5B;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpD   = 8'h44;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpH   = 8'h48;
  localparam logic [7:0] ChUpP   = 8'h50;
  localparam logic [7:0] ChUpS   = 8'h53;

  // Key codes.
  localparam logic [4:0] KChar   = 5'd0;
  localparam logic [4:0] KEscape = 5'd1;
  localparam logic [4:0] KF1     = 5'd2;
  localparam logic [4:0] KF5     = 5'd6;
  localparam logic [4:0] KF6     = 5'd7;
  localparam logic [4:0] KF7     = 5'd8;
  localparam logic [4:0] KF8     = 5'd9;
  localparam logic [4:0] KF9     = 5'd10;
  localparam logic [4:0] KF10    = 5'd11;
  localparam logic [4:0] KF11    = 5'd12;
  localparam logic [4:0] KF12    = 5'd13;
  localparam logic [4:0] KUp     = 5'd14;
  localparam logic [4:0] KHome   = 5'd18;
  localparam logic [4:0] KEnd    = 5'd19;
  localparam logic [4:0] KDelete = 5'd20;
  localparam logic [4:0] KPgUp   = 5'd21;
  localparam logic [4:0] KPgDn   = 5'd22;
  localparam logic [4:0] KResize = 5'd23;

  typedef enum logic [3:0] {
    ClsEsc,
    ClsSs3,
    ClsCsi,
    ClsDigit,
    ClsTilde,
    ClsResize,
    ClsSemi,
    ClsFkey,
    ClsArrow,
    ClsHome,
    ClsEnd,
    ClsOther
  } cls_e;

  typedef enum logic [4:0] {
    PhGround = 5'b00001,
    PhEsc    = 5'b00010,
    PhSs3    = 5'b00100,
    PhCsi    = 5'b01000,
    PhNum    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       idle;
    cls_e       cls;
    logic [3:0] low;
    logic [7:0] data;
  } tok_t;

  function automatic logic [4:0] map_number(input logic [NumW-1:0] v);
    logic [4:0] k;
    k = KEscape;
    unique case (v)
      NumW'(3):  k = KDelete;
      NumW'(5):  k = KPgUp;
      NumW'(6):  k = KPgDn;
      NumW'(15): k = KF5;
      NumW'(17): k = KF6;
      NumW'(18): k = KF7;
      NumW'(19): k = KF8;
      NumW'(20): k = KF9;
      NumW'(21): k = KF10;
      NumW'(23): k = KF11;
      NumW'(24): k = KF12;
      default:   k = KEscape;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/esd_front.sv -----
// ----------------------------------------------------------------------------
// esd_front: input acceptance and byte classification
// Accepts input beats while the queue has room and turns each one into a
// classified token.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_front (
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          req_type_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output esd_pkg::tok_t      q_tok_o
);

  esd_pkg::cls_e cls;
  logic [3:0]    low;

  always_comb begin
    cls = esd_pkg::ClsOther;
    low = rx_byte_i[3:0];
    priority if (rx_byte_i == esd_pkg::ChEsc) begin
      cls = esd_pkg::ClsEsc;
    end else if (rx_byte_i == esd_pkg::ChSs3) begin
      cls = esd_pkg::ClsSs3;
    end else if (rx_byte_i == esd_pkg::ChCsi) begin
      cls = esd_pkg::ClsCsi;
    end else if (rx_byte_i >= esd_pkg::ChZero && rx_byte_i <= esd_pkg::ChNine) begin
      cls = esd_pkg::ClsDigit;
    end else if (rx_byte_i == esd_pkg::ChTilde) begin
      cls = esd_pkg::ClsTilde;
    end else if (rx_byte_i == esd_pkg::ChT) begin
      cls = esd_pkg::ClsResize;
    end else if (rx_byte_i == esd_pkg::ChSemi) begin
      cls = esd_pkg::ClsSemi;
    end else if (rx_byte_i >= esd_pkg::ChUpP && rx_byte_i <= esd_pkg::ChUpS) begin
      cls = esd_pkg::ClsFkey;
      low = 4'(rx_byte_i - esd_pkg::ChUpP);
    end else if (rx_byte_i >= esd_pkg::ChUpA && rx_byte_i <= esd_pkg::ChUpD) begin
      cls = esd_pkg::ClsArrow;
      low = 4'(rx_byte_i - esd_pkg::ChUpA);
    end else if (rx_byte_i == esd_pkg::ChUpH) begin
      cls = esd_pkg::ClsHome;
    end else if (rx_byte_i == esd_pkg::ChUpF) begin
      cls = esd_pkg::ClsEnd;
    end else begin
      cls = esd_pkg::ClsOther;
    end
  end

  assign in_ready_o    = !q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i;
  assign q_tok_o.idle  = req_type_i;
  assign q_tok_o.cls   = cls;
  assign q_tok_o.low   = low;
  assign q_tok_o.data  = rx_byte_i;

endmodule

`default_nettype wire

// ----- rtl/esd_fifo.sv -----
// ----------------------------------------------------------------------------
// esd_fifo: token queue between front end and back end
// A short register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire esd_pkg::tok_t push_tok_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               not_empty_o,
  output esd_pkg::tok_t      pop_tok_o
);

  localparam logic [esd_pkg::QPtrW-1:0] LastIdx = esd_pkg::QPtrW'(esd_pkg::QDepth - 1);
  localparam logic [esd_pkg::QCntW-1:0] FullCnt = esd_pkg::QCntW'(esd_pkg::QDepth);

  esd_pkg::tok_t               mem_q [esd_pkg::QDepth];
  logic [esd_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [esd_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [esd_pkg::QCntW-1:0]   cnt_q, cnt_d;

  assign full_o      = (cnt_q == FullCnt);
  assign not_empty_o = (cnt_q != '0);
  assign pop_tok_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("Queue count exceeds depth.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> cnt_q == FullCnt && $stable(rd_ptr_q))
    else $error("Queue changed while full and not read.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("Queue read while empty.");

endmodule

`default_nettype wire

// ----- rtl/esd_back.sv -----
// ----------------------------------------------------------------------------
// esd_back: escape sequence parser and result register
// Runs the parser on one queued token per cycle while its result register is
// free or being read, and holds each key event there until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_not_empty_i,
  input  wire esd_pkg::tok_t q_tok_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [4:0]         key_kind_o,
  output logic [7:0]         char_value_o
);

  esd_pkg::phase_e              phase_q, phase_d;
  logic [esd_pkg::NumW-1:0]     acc_q, acc_d;
  logic                         out_valid_q, out_valid_d;
  logic [4:0]                   kind_q, kind_d;
  logic [7:0]                   char_q, char_d;
  logic                         emit;
  logic [esd_pkg::ProdW-1:0]    acc_next;

  assign q_pop_o  = q_not_empty_i && (!out_valid_q || out_ready_i);
  assign acc_next = esd_pkg::ProdW'(acc_q) * esd_pkg::ProdW'(10)
                  + esd_pkg::ProdW'(q_tok_i.low);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    kind_d  = esd_pkg::KEscape;
    char_d  = '0;
    if (q_pop_o) begin
      unique case (phase_q)
        esd_pkg::PhEsc: begin
          if (!q_tok_i.idle && q_tok_i.cls == esd_pkg::ClsSs3) begin
            phase_d = esd_pkg::PhSs3;
          end else if (!q_tok_i.idle && q_tok_i.cls == esd_pkg::ClsCsi) begin
            phase_d = esd_pkg::PhCsi;
          end else begin
            emit = 1'b1;
          end
        end
        esd_pkg::PhSs3: begin
          emit = 1'b1;
          if (!q_tok_i.idle && q_tok_i.cls == esd_pkg::ClsFkey) begin
            kind_d = esd_pkg::KF1 + 5'(q_tok_i.low);
          end
        end
        esd_pkg::PhCsi: begin
          if (q_tok_i.idle) begin
            emit = 1'b1;
          end else if (q_tok_i.cls == esd_pkg::ClsDigit) begin
            acc_d   = esd_pkg::NumW'(q_tok_i.low);
            phase_d = esd_pkg::PhNum;
          end else begin
            emit = 1'b1;
            priority case (q_tok_i.cls)
              esd_pkg::ClsArrow: kind_d = esd_pkg::KUp + 5'(q_tok_i.low);
              esd_pkg::ClsHome:  kind_d = esd_pkg::KHome;
              esd_pkg::ClsEnd:   kind_d = esd_pkg::KEnd;
              default:           kind_d = esd_pkg::KEscape;
            endcase
          end
        end
        esd_pkg::PhNum: begin
          if (q_tok_i.idle) begin
            emit   = 1'b1;
            kind_d = esd_pkg::map_number(acc_q);
          end else if (q_tok_i.cls == esd_pkg::ClsResize) begin
            emit   = 1'b1;
            kind_d = esd_pkg::KResize;
          end else if (q_tok_i.cls == esd_pkg::ClsDigit) begin
            acc_d = (acc_next > esd_pkg::ProdW'(esd_pkg::NumMax))
                  ? esd_pkg::NumMax : acc_next[esd_pkg::NumW-1:0];
          end else if (q_tok_i.cls != esd_pkg::ClsSemi) begin
            emit   = 1'b1;
            kind_d = esd_pkg::map_number(acc_q);
          end
        end
        default: begin
          phase_d = esd_pkg::PhGround;
          acc_d   = '0;
          if (!q_tok_i.idle) begin
            if (q_tok_i.cls == esd_pkg::ClsEsc) begin
              phase_d = esd_pkg::PhEsc;
            end else begin
              emit   = 1'b1;
              kind_d = esd_pkg::KChar;
              char_d = q_tok_i.data;
            end
          end
        end
      endcase
      if (emit) begin
        phase_d = esd_pkg::PhGround;
        acc_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= esd_pkg::PhGround;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      char_q <= char_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_kind_o   = kind_q;
  assign char_value_o = char_q;

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != esd_pkg::KChar |-> char_q == '0)
    else $error("Character field is nonzero on a non-character key.");

  a_acc_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != esd_pkg::PhNum |-> acc_q == '0)
    else $error("Number holds a value outside the number phase.");

  a_emit_ground: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> phase_q == esd_pkg::PhGround && out_valid_q)
    else $error("Parser did not return to ground after a key event.");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> kind_q <= esd_pkg::KResize)
    else $error("Key code out of range.");

endmodule

`default_nettype wire

// ----- rtl/escape_sequence_key_decoder.sv -----
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder: terminal input byte stream to key events
// A front end classifies incoming bytes, a two-entry queue decouples it from
// the back end, which parses escape sequences and registers key events.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_ready_o  req_type_i, rx_byte_i
//   out       output     out_valid_o/out_ready_i key_kind_o, char_value_o
//
// One input beat is accepted per cycle while the queue has room.
// A key event passes through its queue entry, the parser step and the result
// register before it appears on the output.
// Reset clears the parser to the ground state and empties queue and output.
// A stalled output holds its event; the queue absorbs two beats before
// in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_key_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       key_kind_o,
  output logic [7:0]       char_value_o
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  esd_pkg::tok_t push_tok;
  esd_pkg::tok_t pop_tok;

  esd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_tok_o    (push_tok)
  );

  esd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_tok_i  (push_tok),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_tok_o   (pop_tok)
  );

  esd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_tok_i       (pop_tok),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_kind_o    (key_kind_o),
    .char_value_o  (char_value_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_escape_sequence_key_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_escape_sequence_key_decoder: self-checking testbench of the key decoder
// A queue of terminal input beats, directed sequences first and then random
// escape sequences mixed with noise, feeds a clocked driver. A clocked monitor
// runs a behavioral parser on every accepted input beat and checks every
// output beat against the oldest predicted key event. Both sides idle in
// random bursts, and the receiver once holds off long enough to back up the
// input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_escape_sequence_key_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StreamLength = 850;
  localparam int unsigned QuietTail    = 120;
  localparam int unsigned DrainIndex   = 400;
  localparam int unsigned HoldAfter    = 150;
  localparam int unsigned HoldCycles   = 100;
  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned KeyNumbers[11] = '{3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};

  typedef struct {
    logic        idle;
    logic [7:0]  data;
    int unsigned gap;
    bit          drain_first;
  } term_beat_t;

  typedef struct {
    logic [4:0] kind;
    logic [7:0] ch;
  } key_event_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       req_type_i  = 1'b1;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [4:0] key_kind_o;
  logic [7:0] char_value_o;

  term_beat_t       byte_stream[$];
  key_event_t       pending_keys[$];
  esd_pkg::phase_e  parse_state = esd_pkg::PhGround;
  logic [9:0]  number_val = '0;
  logic        in_taken = 1'b0;
  int unsigned failures = 0;
  int unsigned key_beats = 0;
  int unsigned stuck_cycles = 0;
  int unsigned gap_mode = 0;
  int unsigned push_count = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned recv_mode = 0;
  int unsigned mode_age = 0;
  bit          long_hold_done = 1'b0;

  escape_sequence_key_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_kind_o   (key_kind_o),
    .char_value_o (char_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [4:0] number_key(input logic [9:0] v);
    logic [4:0] k;
    case (v)
      10'd3:   k = esd_pkg::KDelete;
      10'd5:   k = esd_pkg::KPgUp;
      10'd6:   k = esd_pkg::KPgDn;
      10'd15:  k = esd_pkg::KF5;
      10'd17:  k = esd_pkg::KF6;
      10'd18:  k = esd_pkg::KF7;
      10'd19:  k = esd_pkg::KF8;
      10'd20:  k = esd_pkg::KF9;
      10'd21:  k = esd_pkg::KF10;
      10'd23:  k = esd_pkg::KF11;
      10'd24:  k = esd_pkg::KF12;
      default: k = esd_pkg::KEscape;
    endcase
    return k;
  endfunction

  task automatic decode_beat(input logic idle, input logic [7:0] b);
    key_event_t  ev;
    bit          fire;
    bit          is_digit;
    int unsigned ext;
    fire     = 1'b0;
    ev.kind  = esd_pkg::KEscape;
    ev.ch    = 8'h00;
    is_digit = (b >= esd_pkg::ChZero) && (b <= esd_pkg::ChNine);
    case (parse_state)
      esd_pkg::PhEsc: begin
        if (!idle && b == esd_pkg::ChSs3) parse_state = esd_pkg::PhSs3;
        else if (!idle && b == esd_pkg::ChCsi) parse_state = esd_pkg::PhCsi;
        else fire = 1'b1;
      end
      esd_pkg::PhSs3: begin
        fire = 1'b1;
        if (!idle && b >= esd_pkg::ChUpP && b <= esd_pkg::ChUpS) begin
          ev.kind = esd_pkg::KF1 + 5'(b - esd_pkg::ChUpP);
        end
      end
      esd_pkg::PhCsi: begin
        if (idle) begin
          fire = 1'b1;
        end else if (b >= esd_pkg::ChUpA && b <= esd_pkg::ChUpD) begin
          fire    = 1'b1;
          ev.kind = esd_pkg::KUp + 5'(b - esd_pkg::ChUpA);
        end else if (b == esd_pkg::ChUpH) begin
          fire    = 1'b1;
          ev.kind = esd_pkg::KHome;
        end else if (b == esd_pkg::ChUpF) begin
          fire    = 1'b1;
          ev.kind = esd_pkg::KEnd;
        end else if (is_digit) begin
          number_val  = 10'(b - esd_pkg::ChZero);
          parse_state = esd_pkg::PhNum;
        end else begin
          fire = 1'b1;
        end
      end
      esd_pkg::PhNum: begin
        if (!idle && b == esd_pkg::ChT) begin
          fire    = 1'b1;
          ev.kind = esd_pkg::KResize;
        end else if (!idle && is_digit) begin
          ext = 32'(number_val) * 10 + 32'(b) - 32'(esd_pkg::ChZero);
          number_val = (ext > 32'(esd_pkg::NumMax)) ? esd_pkg::NumMax : 10'(ext);
        end else if (idle || b != esd_pkg::ChSemi) begin
          fire    = 1'b1;
          ev.kind = number_key(number_val);
        end
      end
      default: begin
        if (!idle && b == esd_pkg::ChEsc) begin
          parse_state = esd_pkg::PhEsc;
        end else if (!idle) begin
          fire    = 1'b1;
          ev.kind = esd_pkg::KChar;
          ev.ch   = b;
        end
      end
    endcase
    if (fire) begin
      pending_keys.push_back(ev);
      parse_state = esd_pkg::PhGround;
      number_val  = '0;
    end
  endtask

  task automatic push_beat(input bit idle, input logic [7:0] data);
    term_beat_t tb;
    if (push_count % 40 == 0) gap_mode = $urandom_range(0, 2);
    push_count++;
    tb.idle        = idle;
    tb.data        = data;
    tb.drain_first = 1'b0;
    tb.gap         = 0;
    if ((gap_mode == 1 && $urandom_range(0, 7) == 0) ||
        (gap_mode == 2 && $urandom_range(0, 1) == 0)) begin
      tb.gap = $urandom_range(1, 18);
    end
    byte_stream.push_back(tb);
  endtask

  task automatic push_key(input logic [7:0] data);
    push_beat(1'b0, data);
  endtask

  task automatic push_any();
    if ($urandom_range(0, 7) == 0) push_beat(1'b1, 8'($urandom_range(0, 255)));
    else push_key(8'($urandom_range(0, 255)));
  endtask

  task automatic push_number();
    int unsigned val;
    int unsigned digits[$];
    case ($urandom_range(0, 3))
      0, 1:    val = KeyNumbers[$urandom_range(0, 10)];
      2:       val = $urandom_range(0, 99);
      default: val = $urandom_range(0, 99999);
    endcase
    do begin
      digits.push_front(val % 10);
      val = val / 10;
    end while (val != 0);
    push_key(esd_pkg::ChEsc);
    push_key(esd_pkg::ChCsi);
    if ($urandom_range(0, 9) == 0) push_key(esd_pkg::ChZero);
    foreach (digits[i]) begin
      if (i != 0 && $urandom_range(0, 6) == 0) push_key(esd_pkg::ChSemi);
      push_key(esd_pkg::ChZero + 8'(digits[i]));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: push_key(esd_pkg::ChTilde);
      6:                push_key(esd_pkg::ChT);
      7:                push_beat(1'b1, 8'($urandom_range(0, 255)));
      default:          push_any();
    endcase
  endtask

  task automatic push_sequence();
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: begin
        b = 8'($urandom_range(0, 255));
        push_key((b == esd_pkg::ChEsc) ? 8'h20 : b);
      end
      6: push_beat(1'b1, 8'($urandom_range(0, 255)));
      7: begin
        push_key(esd_pkg::ChEsc);
        push_beat(1'b1, 8'($urandom_range(0, 255)));
      end
      8, 9: begin
        push_key(esd_pkg::ChEsc);
        push_key(esd_pkg::ChSs3);
        if ($urandom_range(0, 3) != 0) push_key(esd_pkg::ChUpP + 8'($urandom_range(0, 3)));
        else push_any();
      end
      10, 11: begin
        push_key(esd_pkg::ChEsc);
        push_key(esd_pkg::ChCsi);
        case ($urandom_range(0, 5))
          0, 1, 2, 3: push_key(esd_pkg::ChUpA + 8'($urandom_range(0, 3)));
          4:          push_key(esd_pkg::ChUpH);
          default:    push_key(esd_pkg::ChUpF);
        endcase
      end
      12, 13, 14, 15, 16: push_number();
      17: begin
        push_key(esd_pkg::ChEsc);
        push_any();
      end
      18: begin
        push_key(esd_pkg::ChEsc);
        push_key(esd_pkg::ChCsi);
        push_any();
      end
      default: push_any();
    endcase
  endtask

  always @(negedge clk_i) begin : drive
    term_beat_t cur;
    logic       next_valid;
    next_valid = in_valid_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      next_valid = 1'b0;
      if (byte_stream.size() != 0) begin
        if (!(byte_stream[0].drain_first && pending_keys.size() != 0)) begin
          if (byte_stream[0].gap != 0) begin
            byte_stream[0].gap = byte_stream[0].gap - 1;
          end else begin
            cur = byte_stream.pop_front();
            req_type_i <= cur.idle;
            rx_byte_i  <= cur.data;
            next_valid = 1'b1;
          end
        end
      end
    end
    in_valid_i <= next_valid;
  end

  always @(negedge clk_i) begin : receive
    logic next_ready;
    next_ready = 1'b1;
    if (mode_age == 0) begin
      recv_mode = $urandom_range(0, 2);
      mode_age  = 50;
    end else begin
      mode_age--;
    end
    if (hold_left != 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (!long_hold_done && key_beats >= HoldAfter) begin
      long_hold_done = 1'b1;
      hold_left      = HoldCycles - 1;
      next_ready     = 1'b0;
    end else if (byte_stream.size() < QuietTail) begin
      next_ready = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else if (recv_mode != 0 &&
                 $urandom_range(0, (recv_mode == 1) ? 9 : 2) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      next_ready = 1'b0;
    end
    out_ready_i <= next_ready;
  end

  always @(posedge clk_i) begin : watch
    key_event_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        decode_beat(req_type_i, rx_byte_i);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        key_beats++;
        if (pending_keys.size() == 0) begin
          $error("unexpected key event: key_kind %0d char_value 0x%02h",
                 key_kind_o, char_value_o);
          failures++;
        end else begin
          want = pending_keys.pop_front();
          if (key_kind_o !== want.kind) begin
            $error("key_kind: expected %0d, actual %0d", want.kind, key_kind_o);
            failures++;
          end
          if (char_value_o !== want.ch) begin
            $error("char_value: expected 0x%02h, actual 0x%02h", want.ch, char_value_o);
            failures++;
          end
        end
      end
      if (moved) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("tb_escape_sequence_key_decoder failed");
        $finish;
      end
    end
  end

  initial begin
    push_key(8'h00);
    push_key(8'hFF);
    push_beat(1'b1, 8'hFF);
    push_key(esd_pkg::ChEsc);
    push_beat(1'b1, 8'h00);
    push_key(esd_pkg::ChEsc);
    push_key(esd_pkg::ChSs3);
    push_key(esd_pkg::ChUpS);
    push_key(esd_pkg::ChEsc);
    push_key(esd_pkg::ChCsi);
    push_key(esd_pkg::ChUpD);
    push_key(esd_pkg::ChEsc);
    push_key(esd_pkg::ChCsi);
    push_key(esd_pkg::ChZero + 8'd2);
    push_key(esd_pkg::ChSemi);
    push_key(esd_pkg::ChZero + 8'd4);
    push_key(esd_pkg::ChTilde);
    push_key(esd_pkg::ChEsc);
    push_key(esd_pkg::ChCsi);
    push_key(esd_pkg::ChNine);
    push_key(esd_pkg::ChT);
    push_key(esd_pkg::ChEsc);
    push_key(esd_pkg::ChCsi);
    repeat (4) push_key(esd_pkg::ChNine);
    push_key(8'h78);
    push_key(esd_pkg::ChEsc);
    push_key(8'h78);
    while (byte_stream.size() < StreamLength) push_sequence();
    for (int i = byte_stream.size() - QuietTail; i < byte_stream.size(); i++) begin
      byte_stream[i].gap = 0;
    end
    byte_stream[DrainIndex].drain_first = 1'b1;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (byte_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_escape_sequence_key_decoder passed");
    end else begin
      $display("tb_escape_sequence_key_decoder failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/esd_pkg.sv
rtl/esd_front.sv
rtl/esd_fifo.sv
rtl/esd_back.sv
rtl/escape_sequence_key_decoder.sv
tb/tb_escape_sequence_key_decoder.sv
